@@ design/topg_pkg.sv @@
`default_nettype none

package topg_pkg;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 8;
    localparam int TempWidth     = 8;
    localparam int MaxResults    = 3;

    localparam logic [CfgIndexWidth-1:0] REG_FEATURE_ENABLE         = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_JUNCTION_LIMIT         = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_LOW_THRESHOLD          = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_INTERMEDIATE_THRESHOLD = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_TOP_SPEED_ALLOWED      = 3'd4;

    typedef enum logic [1:0] {
        PT_600 = 2'd0,
        PT_800 = 2'd1,
        PT_1G  = 2'd2
    } t_point;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_FORCE = 1'b1
    } t_command;

    typedef enum logic {
        KIND_SWITCH = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef struct packed {
        logic                 feature_enable;
        logic [TempWidth-1:0] junction_limit;
        logic [TempWidth-1:0] low_threshold;
        logic [TempWidth-1:0] intermediate_threshold;
        logic                 top_speed_allowed;
    } t_config;

    typedef struct packed {
        t_kind                kind;
        t_point               point;
        logic                 notify;
        logic                 breach;
        logic                 new_max;
        logic [TempWidth-1:0] max_temperature;
        logic                 last;
    } t_result;

    typedef struct packed {
        t_result [MaxResults-1:0] items;
        logic [1:0]               count;
        t_point                   point;
        logic [TempWidth-1:0]     peak;
    } t_decision;

endpackage

`default_nettype wire

@@ design/topg_decide.sv @@
`default_nettype none

module topg_decide (
    input  wire topg_pkg::t_config   i_cfg,
    input  wire topg_pkg::t_command  i_command,
    input  wire logic [7:0]          i_temperature,
    input  wire logic                i_block_top_speed,
    input  wire logic [1:0]          i_requested_point,
    input  wire topg_pkg::t_point    i_point,
    input  wire logic [7:0]          i_peak,
    output topg_pkg::t_decision      o_decision
);
    import topg_pkg::*;

    t_point   req_point;
    t_point   first_point;
    t_point   second_point;
    t_point   mid_point;
    t_point   final_point;
    t_result  status;
    t_result  sw_first;
    t_result  sw_second;
    logic     tick;
    logic     breach;
    logic     sw_breach;
    logic     new_max;
    logic     rise;
    logic     blk;
    logic     sw_mid;
    logic     sw_rec;
    logic [1:0] n_switch;
    logic [7:0] peak_next;
    t_point   live_point;

    always_comb begin
        unique case (i_requested_point)
            2'd1:    req_point = PT_800;
            2'd2:    req_point = PT_1G;
            default: req_point = PT_600;
        endcase
    end

    // The breach, block and recovery rules look at the point held at the start of
    // the step; the rise rule looks at the point after a possible breach drop.
    always_comb begin
        tick       = (i_command == CMD_TICK) && i_cfg.feature_enable;
        breach     = tick && (i_temperature >= i_cfg.junction_limit);
        sw_breach  = breach && (i_point != PT_600);
        new_max    = breach && (i_temperature > i_peak);
        live_point = sw_breach ? PT_600 : i_point;
        rise       = tick && i_cfg.top_speed_allowed
                     && (i_temperature <= i_cfg.low_threshold)
                     && (live_point != PT_1G) && !i_block_top_speed;
        blk        = tick && i_cfg.top_speed_allowed && i_block_top_speed
                     && (i_point == PT_1G);
        sw_mid     = rise || blk;
        mid_point  = rise ? PT_1G : PT_800;
        sw_rec     = tick && (i_temperature <= i_cfg.intermediate_threshold)
                     && (i_point == PT_600);
        peak_next  = new_max ? i_temperature : i_peak;
    end

    always_comb begin
        if (i_command == CMD_FORCE) begin
            n_switch     = 2'd1;
            first_point  = req_point;
            second_point = req_point;
            final_point  = req_point;
        end else begin
            n_switch     = {1'b0, sw_breach} + {1'b0, sw_mid} + {1'b0, sw_rec};
            first_point  = sw_breach ? PT_600 : (sw_mid ? mid_point : PT_800);
            second_point = sw_breach ? mid_point : PT_800;
            if (sw_rec) begin
                final_point = PT_800;
            end else if (sw_mid) begin
                final_point = mid_point;
            end else if (sw_breach) begin
                final_point = PT_600;
            end else begin
                final_point = i_point;
            end
        end
    end

    always_comb begin
        status                 = '0;
        status.kind            = KIND_STATUS;
        status.point           = final_point;
        status.notify          = sw_breach || sw_mid || sw_rec || new_max;
        status.breach          = sw_breach;
        status.new_max         = new_max;
        status.max_temperature = peak_next;
        status.last            = 1'b1;

        sw_first        = '0;
        sw_first.kind   = KIND_SWITCH;
        sw_first.point  = first_point;
        sw_second       = '0;
        sw_second.kind  = KIND_SWITCH;
        sw_second.point = second_point;

        o_decision.items = '0;
        unique case (n_switch)
            2'd0: begin
                o_decision.items[0] = status;
            end
            2'd1: begin
                o_decision.items[0] = sw_first;
                o_decision.items[1] = status;
            end
            default: begin
                o_decision.items[0] = sw_first;
                o_decision.items[1] = sw_second;
                o_decision.items[2] = status;
            end
        endcase
        o_decision.count = (n_switch == 2'd3) ? 2'd3 : n_switch + 2'd1;
        o_decision.point = final_point;
        o_decision.peak  = peak_next;
    end

endmodule

`default_nettype wire

@@ design/thermal_operating_point_governor.sv @@
`default_nettype none

// Thermal operating point governor.
// The slave channel takes one transfer per temperature tick or forced point
// request; tuser carries the command. Five configuration registers are written
// through the plain write port; the user must write them only while the block
// is idle, which the block itself does not enforce.
// Each input transfer produces one to three result transfers on the master
// channel: zero, one or two switch orders and then a status item with tlast
// set. The decision is made in the cycle of acceptance, and the first result
// is offered in the following cycle. Results of one input leave on consecutive
// cycles while the receiver is ready, and a new input is taken in the same
// cycle as the last result of the previous one leaves. The three-entry result
// buffer holds every result of one input.
// When the receiver stalls, the buffered results hold and no input is taken
// until the status item leaves.
// Reset clears the buffer, returns the point to 600 MHz, clears the stored
// maximum and loads the configuration defaults (junction limit 255, all else
// zero).
module thermal_operating_point_governor (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [topg_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  wire logic [topg_pkg::CfgDataWidth-1:0]  i_cfg_data,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [7:0] temperature, [8] block_top_speed, [10:9] requested_point, rest zero
    input  wire logic [15:0] i_s_axis_tdata,
    // [0] command
    input  wire logic        i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [1:0] operating_point, [2] notify, [3] breach_flag, [4] new_max_flag,
    // [12:5] max_temperature, rest zero
    output logic [15:0]      o_m_axis_tdata,
    // [0] item_kind
    output logic             o_m_axis_tuser,
    output logic             o_m_axis_tlast
);
    import topg_pkg::*;

    t_config    r_cfg;
    t_point     r_point;
    logic [7:0] r_peak;
    t_result    r_items [MaxResults];
    logic [1:0] r_cnt;
    t_decision  decision;
    logic       in_xfer;
    logic       out_xfer;

    assign out_xfer        = o_m_axis_tvalid && i_m_axis_tready;
    assign o_s_axis_tready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_m_axis_tready);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    topg_decide u_decide (
        .i_cfg             (r_cfg),
        .i_command         (t_command'(i_s_axis_tuser)),
        .i_temperature     (i_s_axis_tdata[7:0]),
        .i_block_top_speed (i_s_axis_tdata[8]),
        .i_requested_point (i_s_axis_tdata[10:9]),
        .i_point           (r_point),
        .i_peak            (r_peak),
        .o_decision        (decision)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.feature_enable         <= 1'b0;
            r_cfg.junction_limit         <= 8'hff;
            r_cfg.low_threshold          <= 8'd0;
            r_cfg.intermediate_threshold <= 8'd0;
            r_cfg.top_speed_allowed      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FEATURE_ENABLE:         r_cfg.feature_enable <= i_cfg_data[0];
                REG_JUNCTION_LIMIT:         r_cfg.junction_limit <= i_cfg_data;
                REG_LOW_THRESHOLD:          r_cfg.low_threshold <= i_cfg_data;
                REG_INTERMEDIATE_THRESHOLD: r_cfg.intermediate_threshold <= i_cfg_data;
                REG_TOP_SPEED_ALLOWED:      r_cfg.top_speed_allowed <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point <= PT_600;
            r_peak  <= 8'd0;
            r_cnt   <= 2'd0;
        end else if (in_xfer) begin
            r_point <= decision.point;
            r_peak  <= decision.peak;
            r_cnt   <= decision.count;
        end else if (out_xfer) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_items[0] <= decision.items[0];
            r_items[1] <= decision.items[1];
            r_items[2] <= decision.items[2];
        end else if (out_xfer) begin
            r_items[0] <= r_items[1];
            r_items[1] <= r_items[2];
        end
    end

    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign o_m_axis_tdata  = {3'd0, r_items[0].max_temperature, r_items[0].new_max,
                              r_items[0].breach, r_items[0].notify, r_items[0].point};
    assign o_m_axis_tuser  = r_items[0].kind;
    assign o_m_axis_tlast  = r_items[0].last;

endmodule

`default_nettype wire

@@ test/tb_thermal_operating_point_governor.sv @@
`default_nettype none

module tb_thermal_operating_point_governor;

    import topg_pkg::*;

    localparam int CycleLimit   = 200000;
    localparam int RandomPhases = 8;
    localparam int PhaseItems   = 45;
    localparam int HoldCycles   = 60;

    typedef struct {
        bit                   is_cfg;
        logic [2:0]           reg_index;
        logic [7:0]           reg_value;
        t_command             cmd;
        logic [TempWidth-1:0] temp;
        logic                 blk;
        logic [1:0]           req;
        bit                   typed;
        t_result              status;
    } t_row;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tready = 1'b0;
    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [15:0] m_tdata;
    wire logic        m_tuser;
    wire logic        m_tlast;

    // Expected status for a directed row, travelling alongside the offered transfer.
    bit      offer_typed = 1'b0;
    t_result offer_status = '0;

    t_config model_cfg;
    t_point  model_point;
    logic [TempWidth-1:0] model_peak;
    t_result owed_results[$];
    t_row    directed_rows[$];

    int src_gap_pct = 0;
    int sink_stall_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int errors = 0;
    int cycles = 0;
    int items_taken = 0;
    int results_seen = 0;
    int switches_seen = 0;

    thermal_operating_point_governor dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CycleLimit) begin
            $display("%0t: timeout with %0d results outstanding", $time, owed_results.size());
            $display("tb_thermal_operating_point_governor NOT OK");
            $finish;
        end
    end

    // The receiver stalls at random, or holds off for a long stretch when asked to.
    always @(negedge clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HoldCycles;
        end
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    function automatic void order_switch(input t_point pt);
        t_result r;
        r = '0;
        r.kind = KIND_SWITCH;
        r.point = pt;
        owed_results.push_back(r);
        model_point = pt;
    endfunction

    function automatic void apply_governor_rules(input t_command cmd,
                                                 input logic [TempWidth-1:0] temp,
                                                 input logic blk, input logic [1:0] req,
                                                 input bit typed, input t_result typed_status);
        t_point  start_point;
        logic    notify;
        logic    breach;
        logic    new_max;
        t_result st;
        start_point = model_point;
        notify = 1'b0;
        breach = 1'b0;
        new_max = 1'b0;
        if (cmd == CMD_FORCE) begin
            order_switch((req == 2'd3) ? PT_600 : t_point'(req));
        end else if (model_cfg.feature_enable) begin
            if (temp >= model_cfg.junction_limit) begin
                if (start_point != PT_600) begin
                    order_switch(PT_600);
                    breach = 1'b1;
                    notify = 1'b1;
                end
                if (temp > model_peak) begin
                    model_peak = temp;
                    new_max = 1'b1;
                    notify = 1'b1;
                end
            end
            if (model_cfg.top_speed_allowed) begin
                if (temp <= model_cfg.low_threshold && model_point != PT_1G && !blk) begin
                    order_switch(PT_1G);
                    notify = 1'b1;
                end
                if (blk && start_point == PT_1G) begin
                    order_switch(PT_800);
                    notify = 1'b1;
                end
            end
            if (temp <= model_cfg.intermediate_threshold && start_point == PT_600) begin
                order_switch(PT_800);
                notify = 1'b1;
            end
        end
        st = '0;
        st.kind = KIND_STATUS;
        st.point = model_point;
        st.notify = notify;
        st.breach = breach;
        st.new_max = new_max;
        st.max_temperature = model_peak;
        st.last = 1'b1;
        owed_results.push_back(typed ? typed_status : st);
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (owed_results.size() == 0) begin
            $display("%0t: result transfer with nothing expected, actual tdata %0h tuser %0b",
                     $time, m_tdata, m_tuser);
            errors++;
        end else begin
            want = owed_results.pop_front();
            results_seen++;
            if (want.kind == KIND_SWITCH) begin
                switches_seen++;
            end
            check_field("item_kind", 16'(want.kind), 16'(m_tuser));
            check_field("operating_point", 16'(want.point), 16'(m_tdata[1:0]));
            check_field("notify", 16'(want.notify), 16'(m_tdata[2]));
            check_field("breach_flag", 16'(want.breach), 16'(m_tdata[3]));
            check_field("new_max_flag", 16'(want.new_max), 16'(m_tdata[4]));
            check_field("max_temperature", 16'(want.max_temperature), 16'(m_tdata[12:5]));
            check_field("tdata padding", 16'h0, 16'(m_tdata[15:13]));
            check_field("last", 16'(want.last), 16'(m_tlast));
        end
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            if (s_tvalid && s_tready) begin
                items_taken++;
                apply_governor_rules(t_command'(s_tuser), s_tdata[7:0], s_tdata[8],
                                     s_tdata[10:9], offer_typed, offer_status);
            end
        end
    end

    function automatic void row_cfg(input logic [2:0] idx, input logic [7:0] val);
        t_row r;
        r.is_cfg = 1'b1;
        r.reg_index = idx;
        r.reg_value = val;
        r.cmd = CMD_TICK;
        r.temp = '0;
        r.blk = 1'b0;
        r.req = '0;
        r.typed = 1'b0;
        r.status = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void row_item(input t_command cmd, input logic [7:0] temp,
                                     input logic blk, input logic [1:0] req,
                                     input bit typed = 1'b0, input t_point pt = PT_600,
                                     input logic notify = 1'b0, input logic breach = 1'b0,
                                     input logic new_max = 1'b0, input logic [7:0] peak = '0);
        t_row r;
        r.is_cfg = 1'b0;
        r.reg_index = '0;
        r.reg_value = '0;
        r.cmd = cmd;
        r.temp = temp;
        r.blk = blk;
        r.req = req;
        r.typed = typed;
        r.status = '0;
        r.status.kind = KIND_STATUS;
        r.status.point = pt;
        r.status.notify = notify;
        r.status.breach = breach;
        r.status.new_max = new_max;
        r.status.max_temperature = peak;
        r.status.last = 1'b1;
        directed_rows.push_back(r);
    endfunction

    task automatic write_register(input logic [2:0] idx, input logic [7:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        case (idx)
            REG_FEATURE_ENABLE:         model_cfg.feature_enable = val[0];
            REG_JUNCTION_LIMIT:         model_cfg.junction_limit = val;
            REG_LOW_THRESHOLD:          model_cfg.low_threshold = val;
            REG_INTERMEDIATE_THRESHOLD: model_cfg.intermediate_threshold = val;
            REG_TOP_SPEED_ALLOWED:      model_cfg.top_speed_allowed = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        while (owed_results.size() != 0) begin
            @(negedge clk);
        end
        repeat (3) @(negedge clk);
    endtask

    task automatic send_item(input t_command cmd, input logic [7:0] temp, input logic blk,
                             input logic [1:0] req, input bit typed, input t_result status);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = cmd;
        s_tdata = {5'b0, req, blk, temp};
        offer_typed = typed;
        offer_status = status;
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic configure(input logic fe, input logic [7:0] jl, input logic [7:0] low,
                             input logic [7:0] mid, input logic tsa);
        drain_results();
        write_register(REG_FEATURE_ENABLE, {7'b0, fe});
        write_register(REG_JUNCTION_LIMIT, jl);
        write_register(REG_LOW_THRESHOLD, low);
        write_register(REG_INTERMEDIATE_THRESHOLD, mid);
        write_register(REG_TOP_SPEED_ALLOWED, {7'b0, tsa});
    endtask

    initial begin
        t_command cmd;
        logic [7:0] temp;
        logic [7:0] jl;
        logic [7:0] low;
        logic [7:0] mid;
        logic [7:0] base;
        logic blk;
        logic [1:0] req;
        int t;
        int sel;

        model_cfg = '0;
        model_cfg.junction_limit = 8'hff;
        model_point = PT_600;
        model_peak = '0;

        // Reset defaults: feature off, so ticks only report status; forces still act.
        row_item(CMD_TICK, 8'd0, 1'b0, 2'd0, 1'b1, PT_600, 1'b0, 1'b0, 1'b0, 8'd0);
        row_item(CMD_TICK, 8'd255, 1'b1, 2'd3, 1'b1, PT_600, 1'b0, 1'b0, 1'b0, 8'd0);
        row_item(CMD_FORCE, 8'd255, 1'b1, 2'd2, 1'b1, PT_1G, 1'b0, 1'b0, 1'b0, 8'd0);
        row_item(CMD_FORCE, 8'd0, 1'b0, 2'd3, 1'b1, PT_600, 1'b0, 1'b0, 1'b0, 8'd0);
        row_item(CMD_FORCE, 8'd128, 1'b1, 2'd1, 1'b1, PT_800, 1'b0, 1'b0, 1'b0, 8'd0);
        row_cfg(REG_FEATURE_ENABLE, 8'd1);
        row_cfg(REG_JUNCTION_LIMIT, 8'd200);
        row_cfg(REG_LOW_THRESHOLD, 8'd50);
        row_cfg(REG_INTERMEDIATE_THRESHOLD, 8'd100);
        row_cfg(REG_TOP_SPEED_ALLOWED, 8'd1);
        row_item(CMD_TICK, 8'd255, 1'b0, 2'd0, 1'b1, PT_600, 1'b1, 1'b1, 1'b1, 8'd255);
        row_item(CMD_TICK, 8'd0, 1'b0, 2'd0);
        row_item(CMD_TICK, 8'd0, 1'b0, 2'd2);
        // A blocked breach at 1 GHz drops to 600 MHz and then steps to 800 MHz.
        row_item(CMD_TICK, 8'd210, 1'b1, 2'd0);
        row_item(CMD_TICK, 8'd120, 1'b1, 2'd0);
        row_item(CMD_FORCE, 8'd0, 1'b0, 2'd2);
        row_item(CMD_TICK, 8'd75, 1'b1, 2'd0);
        row_item(CMD_TICK, 8'd50, 1'b0, 2'd0);
        row_item(CMD_TICK, 8'd200, 1'b0, 2'd0);
        row_item(CMD_TICK, 8'd100, 1'b0, 2'd0);
        row_item(CMD_TICK, 8'd101, 1'b0, 2'd0);
        row_cfg(REG_JUNCTION_LIMIT, 8'd0);
        row_cfg(REG_LOW_THRESHOLD, 8'd255);
        row_cfg(REG_INTERMEDIATE_THRESHOLD, 8'd255);
        row_cfg(REG_TOP_SPEED_ALLOWED, 8'd0);
        row_item(CMD_TICK, 8'd0, 1'b0, 2'd0);
        row_item(CMD_TICK, 8'd255, 1'b0, 2'd0);
        row_cfg(REG_TOP_SPEED_ALLOWED, 8'd1);
        // The rise rule looks at the live point, so a breach can be followed by 1 GHz.
        row_item(CMD_TICK, 8'd255, 1'b0, 2'd0);
        row_item(CMD_TICK, 8'd128, 1'b1, 2'd0);
        row_cfg(REG_FEATURE_ENABLE, 8'd0);
        row_item(CMD_TICK, 8'd0, 1'b1, 2'd0, 1'b1, PT_800, 1'b0, 1'b0, 1'b0, 8'd255);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                drain_results();
                write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end else begin
                send_item(directed_rows[i].cmd, directed_rows[i].temp, directed_rows[i].blk,
                          directed_rows[i].req, directed_rows[i].typed,
                          directed_rows[i].status);
            end
        end

        for (int phase = 0; phase < RandomPhases; phase++) begin
            jl = 8'($urandom_range(60, 250));
            low = 8'($urandom_range(0, jl / 2));
            mid = 8'($urandom_range(low, jl));
            drain_results();
            case (phase)
                0: configure(1'b1, 8'd255, 8'd0, 8'd0, 1'b1);
                3: configure(1'b0, jl, low, mid, 1'b1);
                6: configure(1'b1, jl, low, mid, 1'b0);
                7: configure(1'b1, 8'd0, 8'd255, 8'd255, 1'b1);
                default: configure(1'b1, jl, low, mid, ($urandom_range(0, 3) != 0));
            endcase
            case (phase % 4)
                0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_gap_pct = 49; sink_stall_pct = 0;  end
                2: begin src_gap_pct = 0;  sink_stall_pct = 49; end
                default: begin src_gap_pct = 8; sink_stall_pct = 8; end
            endcase
            if (phase == 4) begin
                hold_requests++;
            end
            for (int n = 0; n < PhaseItems; n++) begin
                cmd = ($urandom_range(0, 99) < 15) ? CMD_FORCE : CMD_TICK;
                sel = $urandom_range(0, 3);
                case (sel)
                    1: base = model_cfg.junction_limit;
                    2: base = model_cfg.low_threshold;
                    3: base = model_cfg.intermediate_threshold;
                    default: base = 8'($urandom_range(0, 255));
                endcase
                t = int'(base) + int'($urandom_range(0, 8)) - 4;
                if (sel == 0) begin
                    t = int'(base);
                end
                if (t < 0) begin
                    t = 0;
                end
                if (t > 255) begin
                    t = 255;
                end
                temp = 8'(t);
                blk = ($urandom_range(0, 99) < 30);
                req = 2'($urandom_range(0, 3));
                send_item(cmd, temp, blk, req, 1'b0, '0);
            end
        end
        src_gap_pct = 0;
        sink_stall_pct = 0;
        drain_results();
        repeat (5) @(negedge clk);

        $display("Run covered %0d input transfers and %0d result transfers (%0d switch orders),",
                 items_taken, results_seen, switches_seen);
        $display("over %0d random settings, four idling patterns and one long receiver hold-off.",
                 RandomPhases);
        if (errors == 0) begin
            $display("tb_thermal_operating_point_governor OK");
        end else begin
            $display("tb_thermal_operating_point_governor NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
